[design/assert_macros.svh]
// assertion macros used by the beat peak trigger core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define BPTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define BPTE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

[design/bpte_pkg.sv]
// types and constants of the beat peak trigger and envelope core
package bpte_pkg;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam int EV_TRANS0     = 0;
    localparam int EV_TRANS1     = 1;
    localparam int EV_KICK       = 2;
    localparam int EV_SUPER      = 3;
    localparam int EV_CNN        = 4;
    localparam int EV_SUBBASS    = 5;
    localparam int EV_DENSE      = 6;
    localparam int EV_DROP       = 7;
    localparam int EV_DENSE_EXIT = 8;

    localparam logic [15:0] TH_BAND_PEAK = 16'd31456;
    localparam logic [15:0] TH_BAND_CTX  = 16'd27524;
    localparam logic [15:0] TH_OVERALL   = 16'd11796;
    localparam logic [15:0] TH_RISE      = 16'd2949;
    localparam logic [15:0] TH_SUPPRESS  = 16'd13107;
    localparam logic [15:0] TH_ACTIVE    = 16'd3276;
    localparam logic [23:0] TH_KICK      = 24'd10066;
    localparam logic [7:0]  MIN_ONSETS   = 8'd2;
    localparam logic [15:0] FULL         = 16'hFFFF;

    // kick * 50 * 65535, product then shifted down by 24
    localparam logic [21:0] KICK_SCALE = 22'd3276750;
    localparam logic [15:0] RISE_SCALE = 16'd53740;

    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TRANS_FADE   = 2'd1;
    localparam logic [1:0] REG_DROP_FADE    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FR_A,
        ST_FR_B,
        ST_FR_C,
        ST_TICK_T,
        ST_TICK_D,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [9:0]  min_peak_interval_ms;
        logic [15:0] trans_fade;
        logic [15:0] drop_fade;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [15:0] overall_level;
        logic [15:0] band0_transient;
        logic [15:0] band1_transient;
        logic [23:0] kick_flux;
        logic [8:0]  event_bits;
        logic [7:0]  onset_count;
        logic [31:0] timestamp_ms;
        logic [3:0]  decay_steps;
    } item_t;

    typedef struct packed {
        logic        peak_fired;
        logic        peak_suppressed;
        logic        drop_event;
        logic        dense_exit_event;
        logic [15:0] transient_level;
        logic [15:0] drop_level;
        logic        drop_active;
    } result_t;

endpackage

[design/bpte_mul.sv]
// shared registered multiplier used for boom scaling and envelope decay
module bpte_mul (
    input  logic                          aclk,
    input  logic [bpte_pkg::MUL_A_W-1:0]  op_a,
    input  logic [bpte_pkg::MUL_B_W-1:0]  op_b,
    output logic [bpte_pkg::MUL_P_W-1:0]  prod
);

    logic [bpte_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= bpte_pkg::MUL_P_W'(op_a) * bpte_pkg::MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[design/bpte_core.sv]
// sequencer, envelope state and result register of the beat peak trigger
`include "assert_macros.svh"

module bpte_core #(
    parameter int MAX_DECAY_STEPS = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bpte_pkg::cfg_t     cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bpte_pkg::item_t    s_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output bpte_pkg::result_t  m_res
);

    bpte_pkg::state_t  state_reg, state_next;
    bpte_pkg::item_t   item_reg, item_next;
    bpte_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        rem_reg, rem_next;
    logic              chain_reg, chain_next;
    logic [31:0]       last_peak_reg, last_peak_next;
    logic [15:0]       prev_ov_reg, prev_ov_next;
    logic [15:0]       trans_env_reg, trans_env_next;
    logic [15:0]       drop_env_reg, drop_env_next;
    logic              rise_reg, rise_next;
    logic              fired_reg, fired_next;
    logic              supp_reg, supp_next;
    logic [21:0]       kb_reg, kb_next;

    logic [bpte_pkg::MUL_A_W-1:0] mul_a;
    logic [bpte_pkg::MUL_B_W-1:0] mul_b;
    logic [bpte_pkg::MUL_P_W-1:0] prod;
    logic [15:0]                  prod_mid;

    logic [3:0]  steps_in, steps_item;
    logic        onset_peak, low_ctx, rhy_ctx, rise, interval_ok, peak;
    logic [31:0] ts_gap;
    logic [15:0] drop_now, ob, boom;
    logic        is_frame;

    bpte_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_mid = prod[31:16];

    assign steps_in   = (8'(s_item.decay_steps) > 8'(MAX_DECAY_STEPS)) ?
                        4'(MAX_DECAY_STEPS) : s_item.decay_steps;
    assign steps_item = (8'(item_reg.decay_steps) > 8'(MAX_DECAY_STEPS)) ?
                        4'(MAX_DECAY_STEPS) : item_reg.decay_steps;

    // peak decision from the held frame
    always_comb begin
        onset_peak = item_reg.event_bits[bpte_pkg::EV_TRANS0]
                  || item_reg.event_bits[bpte_pkg::EV_TRANS1]
                  || item_reg.event_bits[bpte_pkg::EV_KICK]
                  || item_reg.event_bits[bpte_pkg::EV_SUPER]
                  || item_reg.event_bits[bpte_pkg::EV_CNN]
                  || (item_reg.band0_transient > bpte_pkg::TH_BAND_PEAK)
                  || (item_reg.band1_transient > bpte_pkg::TH_BAND_PEAK);
        low_ctx    = (item_reg.band0_transient > bpte_pkg::TH_BAND_CTX)
                  || (item_reg.band1_transient > bpte_pkg::TH_BAND_CTX)
                  || (item_reg.kick_flux > bpte_pkg::TH_KICK)
                  || item_reg.event_bits[bpte_pkg::EV_SUBBASS];
        rhy_ctx    = item_reg.event_bits[bpte_pkg::EV_SUPER]
                  || (item_reg.onset_count >= bpte_pkg::MIN_ONSETS)
                  || item_reg.event_bits[bpte_pkg::EV_DENSE];
        rise       = (item_reg.overall_level > bpte_pkg::TH_OVERALL)
                  && (item_reg.overall_level > prev_ov_reg)
                  && ((item_reg.overall_level - prev_ov_reg) > bpte_pkg::TH_RISE)
                  && (low_ctx || rhy_ctx);
        ts_gap      = item_reg.timestamp_ms - last_peak_reg;
        interval_ok = (item_reg.timestamp_ms == 32'd0)
                   || ((item_reg.timestamp_ms >= last_peak_reg)
                       && (ts_gap >= 32'(cfg.min_peak_interval_ms)));
        peak        = (onset_peak || rise) && interval_ok;
        drop_now    = item_reg.event_bits[bpte_pkg::EV_DROP] ? bpte_pkg::FULL : drop_env_reg;
        ob          = rise_reg ? prod_mid : item_reg.overall_level;
        if (kb_reg[21:16] != 6'd0) begin
            boom = bpte_pkg::FULL;
        end else if (kb_reg[15:0] > ob) begin
            boom = kb_reg[15:0];
        end else begin
            boom = ob;
        end
    end

    assign is_frame = (item_reg.command == bpte_pkg::CMD_FRAME);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        chain_next     = chain_reg;
        last_peak_next = last_peak_reg;
        prev_ov_next   = prev_ov_reg;
        trans_env_next = trans_env_reg;
        drop_env_next  = drop_env_reg;
        rise_next      = rise_reg;
        fired_next     = fired_reg;
        supp_next      = supp_reg;
        kb_next        = kb_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bpte_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    item_next  = s_item;
                    fired_next = 1'b0;
                    supp_next  = 1'b0;
                    rise_next  = 1'b0;
                    chain_next = 1'b0;
                    rem_next   = steps_in;
                    if (s_item.command == bpte_pkg::CMD_TICK) begin
                        state_next = bpte_pkg::ST_TICK_T;
                    end else begin
                        state_next = bpte_pkg::ST_FR_A;
                    end
                end
            end
            bpte_pkg::ST_FR_A: begin
                mul_a         = item_reg.kick_flux;
                mul_b         = bpte_pkg::KICK_SCALE;
                drop_env_next = drop_now;
                rise_next     = rise;
                supp_next     = peak && (drop_now > bpte_pkg::TH_SUPPRESS);
                fired_next    = peak && !(drop_now > bpte_pkg::TH_SUPPRESS);
                prev_ov_next  = item_reg.overall_level;
                if (peak && (item_reg.timestamp_ms != 32'd0)) begin
                    last_peak_next = item_reg.timestamp_ms;
                end
                state_next = bpte_pkg::ST_FR_B;
            end
            bpte_pkg::ST_FR_B: begin
                mul_a      = bpte_pkg::MUL_A_W'(item_reg.overall_level);
                mul_b      = bpte_pkg::MUL_B_W'(bpte_pkg::RISE_SCALE);
                kb_next    = prod[45:24];
                state_next = bpte_pkg::ST_FR_C;
            end
            bpte_pkg::ST_FR_C: begin
                if (fired_reg && (boom > trans_env_reg)) begin
                    trans_env_next = boom;
                end
                state_next = bpte_pkg::ST_DONE;
            end
            bpte_pkg::ST_TICK_T: begin
                if (chain_reg) begin
                    trans_env_next = prod_mid;
                end
                if (rem_reg != 4'd0) begin
                    mul_a      = bpte_pkg::MUL_A_W'(chain_reg ? prod_mid : trans_env_reg);
                    mul_b      = bpte_pkg::MUL_B_W'(cfg.trans_fade);
                    rem_next   = rem_reg - 4'd1;
                    chain_next = 1'b1;
                end else begin
                    chain_next = 1'b0;
                    rem_next   = steps_item;
                    state_next = bpte_pkg::ST_TICK_D;
                end
            end
            bpte_pkg::ST_TICK_D: begin
                if (chain_reg) begin
                    drop_env_next = prod_mid;
                end
                if (rem_reg != 4'd0) begin
                    mul_a      = bpte_pkg::MUL_A_W'(chain_reg ? prod_mid : drop_env_reg);
                    mul_b      = bpte_pkg::MUL_B_W'(cfg.drop_fade);
                    rem_next   = rem_reg - 4'd1;
                    chain_next = 1'b1;
                end else begin
                    chain_next = 1'b0;
                    state_next = bpte_pkg::ST_DONE;
                end
            end
            bpte_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_next.peak_fired       = fired_reg;
                    out_next.peak_suppressed  = supp_reg;
                    out_next.drop_event       = is_frame
                                             && item_reg.event_bits[bpte_pkg::EV_DROP];
                    out_next.dense_exit_event = is_frame
                                             && item_reg.event_bits[bpte_pkg::EV_DENSE_EXIT];
                    out_next.transient_level  = trans_env_reg;
                    out_next.drop_level       = drop_env_reg;
                    out_next.drop_active      = drop_env_reg > bpte_pkg::TH_ACTIVE;
                    out_valid_next            = 1'b1;
                    state_next                = bpte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpte_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= 4'd0;
            chain_reg     <= 1'b0;
            last_peak_reg <= 32'd0;
            prev_ov_reg   <= 16'd0;
            trans_env_reg <= 16'd0;
            drop_env_reg  <= 16'd0;
            rise_reg      <= 1'b0;
            fired_reg     <= 1'b0;
            supp_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            chain_reg     <= chain_next;
            last_peak_reg <= last_peak_next;
            prev_ov_reg   <= prev_ov_next;
            trans_env_reg <= trans_env_next;
            drop_env_reg  <= drop_env_next;
            rise_reg      <= rise_next;
            fired_reg     <= fired_next;
            supp_reg      <= supp_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
        kb_reg   <= kb_next;
    end

    assign s_tready = (state_reg == bpte_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    `BPTE_ASSERT(a_fire_xor_supp, m_tvalid |-> !(m_res.peak_fired && m_res.peak_suppressed), "peak both fired and suppressed")
    `BPTE_ASSERT(a_tick_no_flags, (state_reg == bpte_pkg::ST_DONE && item_reg.command == bpte_pkg::CMD_TICK) |-> (!fired_reg && !supp_reg), "tick carries peak flags")
    `BPTE_ASSERT(a_drop_full, (state_reg == bpte_pkg::ST_FR_B && item_reg.event_bits[bpte_pkg::EV_DROP]) |-> (drop_env_reg == bpte_pkg::FULL), "drop event did not fill envelope")
    `BPTE_ASSERT(a_rem_bound, 1'b1 |-> (8'(rem_reg) <= 8'(MAX_DECAY_STEPS)), "decay step count above limit")
    `BPTE_ASSERT_NEXT(a_done_loads, (state_reg == bpte_pkg::ST_DONE && (!out_valid_reg || m_tready)), (m_tvalid && state_reg == bpte_pkg::ST_IDLE), "finished result not loaded")

endmodule

[design/beat_peak_trigger_envelope_core.sv]
// top level: stream ports, register file and the peak and envelope sequencer
//
//  channel   dir  beat content
//  s_        in   one frame or decay tick per beat (kind in s_tuser)
//  m_        out  one result beat per input beat
//  apb       in   register writes and reads, pready tied high
//
// a feature frame runs FR_A, FR_B, FR_C and DONE up to a loaded result register
// a decay tick runs n steps per envelope, n = min(decay_steps, MAX_DECAY_STEPS),
// on the single shared multiplier doing one decay step per cycle
// s_tready is high only while the sequencer is idle; a result waiting on
// m_tready does not block the next input beat, only its completion
// aresetn is synchronous; it clears envelopes, peak time and previous level
module beat_peak_trigger_envelope_core #(
    parameter int MAX_DECAY_STEPS = 15
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // overall_level, band0_transient, band1_transient, kick_flux, event_bits,
    // onset_count, timestamp_ms, decay_steps, zero fill
    input  logic [127:0] s_tdata,
    // command
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // peak_fired, peak_suppressed, drop_event, dense_exit_event,
    // transient_level, drop_level, drop_active, zero fill
    output logic [39:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    bpte_pkg::cfg_t    cfg_reg, cfg_next;
    bpte_pkg::item_t   s_item;
    bpte_pkg::result_t m_res;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                bpte_pkg::REG_MIN_INTERVAL: cfg_next.min_peak_interval_ms = pwdata[9:0];
                bpte_pkg::REG_TRANS_FADE:   cfg_next.trans_fade           = pwdata[15:0];
                bpte_pkg::REG_DROP_FADE:    cfg_next.drop_fade            = pwdata[15:0];
                default:                    cfg_next                      = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bpte_pkg::REG_MIN_INTERVAL: prdata = 32'(cfg_reg.min_peak_interval_ms);
            bpte_pkg::REG_TRANS_FADE:   prdata = 32'(cfg_reg.trans_fade);
            bpte_pkg::REG_DROP_FADE:    prdata = 32'(cfg_reg.drop_fade);
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_peak_interval_ms <= 10'd175;
            cfg_reg.trans_fade           <= 16'd55705;
            cfg_reg.drop_fade            <= 16'd62259;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        s_item.command         = s_tuser[0];
        s_item.overall_level   = s_tdata[15:0];
        s_item.band0_transient = s_tdata[31:16];
        s_item.band1_transient = s_tdata[47:32];
        s_item.kick_flux       = s_tdata[71:48];
        s_item.event_bits      = s_tdata[80:72];
        s_item.onset_count     = s_tdata[88:81];
        s_item.timestamp_ms    = s_tdata[120:89];
        s_item.decay_steps     = s_tdata[124:121];
    end

    bpte_core #(
        .MAX_DECAY_STEPS (MAX_DECAY_STEPS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {3'd0,
                      m_res.drop_active,
                      m_res.drop_level,
                      m_res.transient_level,
                      m_res.dense_exit_event,
                      m_res.drop_event,
                      m_res.peak_suppressed,
                      m_res.peak_fired};

endmodule

[tb/tb.sv]
// testbench for the beat peak trigger and envelope core: stream driver, predictor and checker
`timescale 1ns / 100ps

module tb;

    localparam int STEP_CAP    = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_BEATS = 100;

    class peak_env_model;
        bpte_pkg::cfg_t    cfg;
        logic [31:0]       last_peak;
        logic [15:0]       prev_overall;
        logic [15:0]       trans_env;
        logic [15:0]       drop_env;
        bpte_pkg::result_t pending_results[$];
        int                errors;

        function new();
            cfg.min_peak_interval_ms = 10'd175;
            cfg.trans_fade           = 16'd55705;
            cfg.drop_fade            = 16'd62259;
            last_peak    = '0;
            prev_overall = '0;
            trans_env    = '0;
            drop_env     = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                bpte_pkg::REG_MIN_INTERVAL: cfg.min_peak_interval_ms = val[9:0];
                bpte_pkg::REG_TRANS_FADE:   cfg.trans_fade = val[15:0];
                bpte_pkg::REG_DROP_FADE:    cfg.drop_fade = val[15:0];
                default: ;
            endcase
        endfunction

        function void predict_item(bpte_pkg::item_t it);
            bpte_pkg::result_t r;
            logic [8:0]        ev;
            logic              onset, low_ctx, rhy_ctx, rise, interval_ok, peak;
            longint            diff;
            logic [63:0]       kb, ob, boom;
            int                steps;
            r  = '0;
            ev = it.event_bits;
            if (it.command == bpte_pkg::CMD_TICK) begin
                steps = (it.decay_steps > STEP_CAP) ? STEP_CAP : it.decay_steps;
                for (int i = 0; i < steps; i++) begin
                    trans_env = 16'((32'(trans_env) * 32'(cfg.trans_fade)) >> 16);
                end
                for (int i = 0; i < steps; i++) begin
                    drop_env = 16'((32'(drop_env) * 32'(cfg.drop_fade)) >> 16);
                end
            end else begin
                r.drop_event       = ev[bpte_pkg::EV_DROP];
                r.dense_exit_event = ev[bpte_pkg::EV_DENSE_EXIT];
                if (ev[bpte_pkg::EV_DROP]) drop_env = 16'hFFFF;
                onset = ev[bpte_pkg::EV_TRANS0] || ev[bpte_pkg::EV_TRANS1] ||
                        ev[bpte_pkg::EV_KICK] || ev[bpte_pkg::EV_SUPER] ||
                        ev[bpte_pkg::EV_CNN] || it.band0_transient > 16'd31456 ||
                        it.band1_transient > 16'd31456;
                low_ctx = it.band0_transient > 16'd27524 || it.band1_transient > 16'd27524 ||
                          it.kick_flux > 24'd10066 || ev[bpte_pkg::EV_SUBBASS];
                rhy_ctx = ev[bpte_pkg::EV_SUPER] || it.onset_count >= 8'd2 ||
                          ev[bpte_pkg::EV_DENSE];
                diff = longint'(it.overall_level) - longint'(prev_overall);
                rise = it.overall_level > 16'd11796 && diff > 64'sd2949 && (low_ctx || rhy_ctx);
                interval_ok = it.timestamp_ms == 0 ||
                    (longint'(it.timestamp_ms) - longint'(last_peak) >=
                     longint'(cfg.min_peak_interval_ms));
                peak = (onset || rise) && interval_ok;
                if (peak && it.timestamp_ms != 0) last_peak = it.timestamp_ms;
                if (peak) begin
                    if (drop_env > 16'd13107) begin
                        r.peak_suppressed = 1'b1;
                    end else begin
                        kb = (64'(it.kick_flux) * 64'd50 * 64'd65535) >> 24;
                        ob = rise ? ((64'(it.overall_level) * 64'd53740) >> 16)
                                  : 64'(it.overall_level);
                        boom = (kb > ob) ? kb : ob;
                        if (boom > 64'd65535) boom = 64'd65535;
                        r.peak_fired = 1'b1;
                        if (boom[15:0] > trans_env) trans_env = boom[15:0];
                    end
                end
                prev_overall = it.overall_level;
            end
            r.transient_level = trans_env;
            r.drop_level      = drop_env;
            r.drop_active     = drop_env > 16'd3276;
            pending_results.push_back(r);
        endfunction

        function void compare_result(logic [39:0] d);
            bpte_pkg::result_t got, want;
            got.peak_fired       = d[0];
            got.peak_suppressed  = d[1];
            got.drop_event       = d[2];
            got.dense_exit_event = d[3];
            got.transient_level  = d[19:4];
            got.drop_level       = d[35:20];
            got.drop_active      = d[36];
            if (pending_results.size() == 0) begin
                if (errors < 10) $display("unexpected result beat %h", d);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.peak_fired !== want.peak_fired ||
                got.peak_suppressed !== want.peak_suppressed ||
                got.drop_event !== want.drop_event ||
                got.dense_exit_event !== want.dense_exit_event ||
                got.transient_level !== want.transient_level ||
                got.drop_level !== want.drop_level ||
                got.drop_active !== want.drop_active) begin
                if (errors < 10) begin
                    $display("mismatch exp fired=%0d supp=%0d drop=%0d dexit=%0d trans=%0d dlev=%0d act=%0d",
                             want.peak_fired, want.peak_suppressed, want.drop_event,
                             want.dense_exit_event, want.transient_level, want.drop_level,
                             want.drop_active);
                    $display("         got fired=%0d supp=%0d drop=%0d dexit=%0d trans=%0d dlev=%0d act=%0d",
                             got.peak_fired, got.peak_suppressed, got.drop_event,
                             got.dense_exit_event, got.transient_level, got.drop_level,
                             got.drop_active);
                end
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    peak_env_model model = new();
    bit            idle_en;
    int unsigned   cycles;
    logic [31:0]   ts_now;
    logic [15:0]   walk_level;

    beat_peak_trigger_envelope_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.compare_result(m_tdata);
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    function automatic bpte_pkg::item_t make_frame(logic [15:0] overall, logic [15:0] b0,
                                                   logic [15:0] b1, logic [23:0] kick,
                                                   logic [8:0] ev, logic [7:0] onsets,
                                                   logic [31:0] ts);
        bpte_pkg::item_t it;
        it = '0;
        it.command         = bpte_pkg::CMD_FRAME;
        it.overall_level   = overall;
        it.band0_transient = b0;
        it.band1_transient = b1;
        it.kick_flux       = kick;
        it.event_bits      = ev;
        it.onset_count     = onsets;
        it.timestamp_ms    = ts;
        return it;
    endfunction

    function automatic bpte_pkg::item_t make_tick(logic [3:0] steps);
        bpte_pkg::item_t it;
        it = '0;
        it.command     = bpte_pkg::CMD_TICK;
        it.decay_steps = steps;
        return it;
    endfunction

    function automatic logic [15:0] pick_band();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(31446, 31466));
            2: return 16'($urandom_range(27514, 27534));
            default: return 16'($urandom_range(0, 20000));
        endcase
    endfunction

    function automatic bpte_pkg::item_t rand_item();
        bpte_pkg::item_t it;
        int unsigned     sel;
        it = '0;
        it.command = ($urandom_range(0, 9) < 3) ? bpte_pkg::CMD_TICK : bpte_pkg::CMD_FRAME;
        if ($urandom_range(0, 1) == 0) begin
            sel = walk_level + $urandom_range(0, 9000);
            walk_level = (sel > 65535) ? 16'hFFFF : 16'(sel);
        end else begin
            walk_level = 16'($urandom_range(0, 65535));
        end
        it.overall_level   = walk_level;
        it.band0_transient = pick_band();
        it.band1_transient = pick_band();
        it.kick_flux = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                   : 24'($urandom_range(0, 20000));
        if ($urandom_range(0, 9) == 0) begin
            it.event_bits = 9'($urandom_range(0, 511));
        end else begin
            for (int b = 0; b < 9; b++) it.event_bits[b] = ($urandom_range(0, 4) == 0);
            it.event_bits[bpte_pkg::EV_DROP] = ($urandom_range(0, 11) == 0);
        end
        it.onset_count = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 3));
        sel = $urandom_range(0, 19);
        if (sel < 17) begin
            ts_now = ts_now + $urandom_range(0, 400);
            it.timestamp_ms = ts_now;
        end else if (sel == 17) begin
            it.timestamp_ms = '0;
        end else if (sel == 18) begin
            it.timestamp_ms = $urandom();
        end else begin
            it.timestamp_ms = ts_now - $urandom_range(1, 200);
        end
        it.decay_steps = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic send_beat(bpte_pkg::item_t it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.command;
        s_tdata  = {3'b000, it.decay_steps, it.timestamp_ms, it.onset_count, it.event_bits,
                    it.kick_flux, it.band1_transient, it.band0_transient, it.overall_level};
        do @(posedge aclk); while (!s_tready);
        model.predict_item(it);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (model.pending_results.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        model.set_reg(idx, val);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        int unsigned min_iv[PHASES];
        int unsigned t_dec[PHASES];
        int unsigned d_dec[PHASES];
        min_iv   = '{175, 0, 1023, 155, 0, 1, 300};
        t_dec    = '{55705, 65535, 0, 30000, 0, 65535, 55705};
        d_dec    = '{62259, 0, 65535, 40000, 0, 65535, 62259};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_en  = 1'b1;
        cycles   = 0;
        ts_now   = 32'd7000;
        walk_level = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed beats under reset settings
        send_beat(make_frame(16'd0, 16'd0, 16'd0, 24'd0, 9'd0, 8'd0, 32'd0));
        send_beat(make_frame(16'd40000, 16'd0, 16'd0, 24'd0, 9'h001, 8'd0, 32'd1000));
        send_beat(make_tick(4'd15));
        send_beat(make_frame(16'd30000, 16'd0, 16'd0, 24'd0, 9'h002, 8'd0, 32'd1100));
        send_beat(make_frame(16'd100, 16'd0, 16'd0, 24'hFFFFFF, 9'h004, 8'd0, 32'd1175));
        send_beat(make_tick(4'd0));
        send_beat(make_frame(16'd0, 16'd31456, 16'd0, 24'd10066, 9'd0, 8'd1, 32'd2000));
        send_beat(make_frame(16'd0, 16'd0, 16'd31457, 24'd0, 9'd0, 8'd0, 32'd2500));
        send_beat(make_frame(16'd20000, 16'd0, 16'd0, 24'd0, 9'h088, 8'd0, 32'd3000));
        send_beat(make_frame(16'd20000, 16'd0, 16'd0, 24'd0, 9'h110, 8'd0, 32'd3500));
        send_beat(make_tick(4'd15));
        send_beat(make_tick(4'd15));
        send_beat(make_tick(4'd15));
        send_beat(make_tick(4'd15));
        send_beat(make_frame(16'd5000, 16'd0, 16'd0, 24'd0, 9'd0, 8'd0, 32'd5000));
        send_beat(make_frame(16'd20000, 16'd0, 16'd0, 24'd0, 9'h020, 8'd0, 32'd6000));
        send_beat(make_frame(16'hFFFF, 16'd0, 16'd0, 24'd0, 9'h040, 8'd2, 32'd6500));
        send_beat(make_frame(16'd11797, 16'd27525, 16'd0, 24'd0, 9'd0, 8'd0, 32'd7000));
        send_beat(make_frame(16'd1000, 16'd0, 16'd0, 24'd0, 9'h001, 8'd0, 32'd100));
        send_beat(make_frame(16'd1000, 16'd0, 16'd0, 24'd0, 9'h001, 8'd0, 32'd0));
        send_beat(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 9'h1FF, 8'hFF,
                             32'hFFFFFFFF));
        send_beat(make_tick(4'd15));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                min_iv[ph] = $urandom_range(0, 1023);
                t_dec[ph]  = $urandom_range(0, 65535);
                d_dec[ph]  = $urandom_range(0, 65535);
            end
            write_reg(bpte_pkg::REG_MIN_INTERVAL, min_iv[ph]);
            write_reg(bpte_pkg::REG_TRANS_FADE, t_dec[ph]);
            write_reg(bpte_pkg::REG_DROP_FADE, d_dec[ph]);
            idle_en = (ph != PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) send_beat(rand_item());
            drain();
        end

        if (model.errors == 0 && model.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/bpte_pkg.sv
design/bpte_mul.sv
design/bpte_core.sv
design/beat_peak_trigger_envelope_core.sv
tb/tb.sv
